### hdl/sliding_window_duplicate_detector_defines.svh
// Assertion macros for the sliding window duplicate detector.
// No dependencies.
`ifndef SLIDING_WINDOW_DUPLICATE_DETECTOR_DEFINES_SVH
`define SLIDING_WINDOW_DUPLICATE_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SWDD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SWDD_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SWDD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SWDD_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

### hdl/swdd_pkg.sv
// Shared types and codes for the sliding window duplicate detector.
// No dependencies.
package swdd_pkg;
  localparam int unsigned TAG_W = 64;
  localparam int unsigned WORD_W = 64;
  // window size in bits; power of two, position math wraps at its width
  localparam int unsigned WINDOW_BITS = 32768;
  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef enum logic {OP_CHECK = 1'b0, OP_CLEAR = 1'b1} op_t;
endpackage

### hdl/sliding_window_duplicate_detector.sv
// Sliding window duplicate detector: one result beat per input beat, one beat in flight at a
// time. Check behind the newest tag: states READ, EVAL and SET, result registered after SET;
// next beat taken as the result leaves. Advance over n bitmap words (1..WINDOW_BITS/64, one
// word a cycle) adds SWEEP and OUT; restart or clear sweeps all 512 words. Unknown ring:
// result in the next cycle. Out stalls add delay. Sync reset, then a clearing pass over all
// RING_COUNT*WINDOW_BITS/64 words (4096), in_stall high. Uses swdd_pkg and the defines header.
`include "sliding_window_duplicate_detector_defines.svh"
module sliding_window_duplicate_detector #(
  parameter int unsigned RING_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [2:0]  in_ring_id,
  input  logic [63:0] in_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_duplicate
);
  localparam int unsigned WINDOW_BITS = swdd_pkg::WINDOW_BITS;
  localparam int unsigned WPR = WINDOW_BITS / 64;
  localparam int unsigned WA_W = (WPR > 1) ? $clog2(WPR) : 1;
  localparam int unsigned POS_W = $clog2(WINDOW_BITS);
  localparam int unsigned RG_W = (RING_COUNT > 1) ? $clog2(RING_COUNT) : 1;
  localparam int unsigned ADDR_W = RG_W + WA_W;
  localparam int unsigned DEPTH = RING_COUNT * WPR;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_READ, S_EVAL, S_SWEEP, S_SET, S_OUT
  } state_t;

  // Bitmap memory, one read port, one write port, registered read.
  swdd_pkg::word_t mem [DEPTH];
  swdd_pkg::word_t rd_data;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  swdd_pkg::word_t   wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  // Per-ring newest tag and position (small, flops).
  swdd_pkg::tag_t   ntag_r [RING_COUNT];
  logic [POS_W-1:0] npos_r [RING_COUNT];

  state_t            state_r;
  logic [ADDR_W:0]   init_cnt_r;
  logic [RG_W-1:0]   ring_r;
  swdd_pkg::tag_t    tag_r;
  logic              clr_r;
  logic [POS_W-1:0]  p_r;        // target bit position
  logic [WA_W:0]     sweep_n_r;  // words left to zero
  logic [WA_W-1:0]   sweep_w_r;  // current word
  logic              dup_r;
  logic              out_valid_r;
  logic              restart_r;

  // Evaluation of the read item against its ring.
  swdd_pkg::tag_t   cur_tag;
  logic [POS_W-1:0] cur_pos;
  logic             ahead;
  swdd_pkg::tag_t   diff;
  logic             in_win;
  logic [POS_W-1:0] dlo;
  logic [POS_W-1:0] tgt;
  logic [WA_W-1:0]  wspan;
  logic [WA_W:0]    adv_words;

  always_comb begin
    cur_tag = ntag_r[ring_r];
    cur_pos = npos_r[ring_r];
    ahead = tag_r > cur_tag;
    diff = ahead ? tag_r - cur_tag : cur_tag - tag_r;
    in_win = diff < swdd_pkg::tag_t'(WINDOW_BITS);
    dlo = diff[POS_W-1:0];
    tgt = ahead ? cur_pos + dlo : cur_pos - dlo;
    // words from the old position's word to the target word, circularly;
    // a wrap back into the same word touches every word
    wspan = tgt[POS_W-1:6] - cur_pos[POS_W-1:6];
    adv_words = (wspan == '0 && tgt < cur_pos) ? (WA_W+1)'(WPR)
                                                : {1'b0, wspan} + (WA_W+1)'(1);
  end

  logic             ring_ok;
  assign ring_ok = 32'(in_ring_id) < RING_COUNT;

  // Mask for one word of an advance: clear bits in (cur_pos, tgt] range.
  logic [POS_W-1:0] base;
  swdd_pkg::word_t  keep;
  always_comb begin
    base = {sweep_w_r, 6'd0};
    for (int i = 0; i < 64; i++) begin
      // offset of this bit after cur_pos, circularly
      keep[i] = ((POS_W'(base + POS_W'(i)) - npos_r[ring_r]) == '0) ||
                ((POS_W'(base + POS_W'(i)) - npos_r[ring_r]) > p_r - npos_r[ring_r]);
    end
  end

  // Next beat may enter in the cycle the pending result leaves.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;
  assign out_duplicate = dup_r;

  logic out_set;
  assign out_set = (state_r == S_SET) ||
                   (state_r == S_IDLE && in_valid && !in_stall && !ring_ok);

  always_comb begin
    we = 1'b0;
    waddr = {ring_r, sweep_w_r};
    wdata = '0;
    raddr = {ring_r, sweep_w_r};
    case (state_r)
      S_INIT: begin
        we = 1'b1;
        waddr = init_cnt_r[ADDR_W-1:0];
      end
      S_READ: raddr = {ring_r, tgt[POS_W-1:6]};
      S_EVAL: begin
        // check path keeps the target word; sweep path fetches its first word
        if (sweep_n_r == '0) begin
          raddr = {ring_r, p_r[POS_W-1:6]};
        end
      end
      S_SWEEP: begin
        we = 1'b1;
        wdata = (clr_r || restart_r) ? '0 : (rd_data & keep);
        raddr = {ring_r, sweep_w_r + WA_W'(1)};
      end
      S_OUT: raddr = {ring_r, p_r[POS_W-1:6]};
      S_SET: begin
        we = !clr_r;
        waddr = {ring_r, p_r[POS_W-1:6]};
        wdata = rd_data | (swdd_pkg::word_t'(1) << p_r[5:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_cnt_r <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < RING_COUNT; r++) begin
        ntag_r[r] <= '0;
        npos_r[r] <= '0;
      end
    end else begin
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          init_cnt_r <= init_cnt_r + 1'b1;
          if (init_cnt_r == (ADDR_W+1)'(DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            if (!ring_ok) begin
              dup_r <= 1'b0;
            end else begin
              ring_r <= RG_W'(in_ring_id);
              tag_r <= in_tag;
              clr_r <= (in_operation == swdd_pkg::OP_CLEAR);
              state_r <= S_READ;
            end
          end
        end
        S_READ: begin
          // ring state is in flops; decide path, target word read is in flight
          dup_r <= 1'b0;
          restart_r <= !in_win;
          if (clr_r || !in_win) begin
            sweep_w_r <= '0;
            sweep_n_r <= (WA_W+1)'(WPR);
            p_r <= '0;
            state_r <= S_EVAL;
          end else if (ahead) begin
            p_r <= tgt;
            sweep_w_r <= cur_pos[POS_W-1:6];
            sweep_n_r <= adv_words;
            state_r <= S_EVAL;
          end else begin
            p_r <= tgt;
            sweep_n_r <= '0;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= (sweep_n_r != '0) ? S_SWEEP : S_SET;
          if (sweep_n_r == '0) begin
            dup_r <= rd_data[p_r[5:0]];
          end
        end
        S_SWEEP: begin
          sweep_w_r <= sweep_w_r + WA_W'(1);
          sweep_n_r <= sweep_n_r - 1'b1;
          if (sweep_n_r == (WA_W+1)'(1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // re-read target word after sweep writes
          state_r <= S_SET;
        end
        S_SET: begin
          if (clr_r) begin
            ntag_r[ring_r] <= '0;
            dup_r <= 1'b0;
          end else begin
            ntag_r[ring_r] <= (ahead || restart_r) ? tag_r : ntag_r[ring_r];
          end
          npos_r[ring_r] <= clr_r ? '0 : ((ahead || restart_r) ? p_r : npos_r[ring_r]);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SWDD_ASSERT(a_one_out, clk, rst_n, (state_r == S_SET) |=> out_valid_r,
               "result not raised after write back")
  `SWDD_ASSERT(a_stall_busy, clk, rst_n, (state_r != S_IDLE) |-> in_stall,
               "input taken while busy")
  `SWDD_ASSERT(a_no_dup_clear, clk, rst_n,
               (state_r == S_SET && clr_r) |=> !dup_r, "clear reported duplicate")
endmodule

### bench/testbench.sv
// Self-checking bench for sliding_window_duplicate_detector.
// Drives check/clear beats through a queue-fed driver and compares every result beat
// with a behavioral copy of the per-ring window bitmaps. Depends on swdd_pkg and the RTL.
module testbench;

  localparam int unsigned WIN   = 32768;
  localparam int unsigned RINGS = 8;

  typedef struct packed {
    swdd_pkg::op_t  op;
    logic [2:0]     ring;
    swdd_pkg::tag_t tag;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic [2:0] in_ring_id = '0;
  logic [63:0] in_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_duplicate;

  sliding_window_duplicate_detector u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_ring_id(in_ring_id), .in_tag(in_tag),
    .out_valid(out_valid), .out_stall(out_stall), .out_duplicate(out_duplicate)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the block: newest tag, its bitmap slot and the bitmap, per ring.
  swdd_pkg::tag_t win_newest [RINGS];
  int unsigned    win_slot   [RINGS];
  bit             win_seen   [RINGS][WIN];

  beat_t          pending_beats[$];   // waiting for the driver
  logic           dup_expected[$];    // one expected duplicate flag per accepted beat
  swdd_pkg::tag_t gen_newest [RINGS]; // generator's own idea of each ring's newest tag

  int send_idle_pct = 0;     // sender gap chance, percent
  int stall_pct = 0;         // receiver stall chance, percent
  int mismatches = 0;
  bit in_took = 1'b0;

  task automatic ring_wipe(input int unsigned r);
    win_newest[r] = '0;
    win_slot[r] = 0;
    for (int i = 0; i < WIN; i++) win_seen[r][i] = 1'b0;
  endtask

  // Applies one accepted beat and returns the duplicate flag it must produce.
  task automatic window_update(input beat_t b, output logic dup);
    int unsigned r;
    int unsigned p;
    swdd_pkg::tag_t gap;
    r = b.ring;
    dup = 1'b0;
    if (b.op == swdd_pkg::OP_CLEAR) begin
      ring_wipe(r);
    end else if (b.tag > win_newest[r] && (b.tag - win_newest[r]) < WIN) begin
      // advance: clear skipped slots, mark the new one
      gap = b.tag - win_newest[r];
      p = win_slot[r];
      for (int k = 1; k < int'(gap); k++) begin
        p = (p + 1) % WIN;
        win_seen[r][p] = 1'b0;
      end
      p = (win_slot[r] + int'(gap)) % WIN;
      win_seen[r][p] = 1'b1;
      win_newest[r] = b.tag;
      win_slot[r] = p;
    end else if (b.tag <= win_newest[r] && (win_newest[r] - b.tag) < WIN) begin
      gap = win_newest[r] - b.tag;
      p = (win_slot[r] + WIN - int'(gap)) % WIN;
      dup = win_seen[r][p];
      win_seen[r][p] = 1'b1;
    end else begin
      // too far either way: ring restarts with just this tag at slot 0
      ring_wipe(r);
      win_newest[r] = b.tag;
      win_seen[r][0] = 1'b1;
    end
  endtask

  task automatic queue_beat(input swdd_pkg::op_t op, input int unsigned r,
                            input swdd_pkg::tag_t t);
    beat_t b;
    b.op = op;
    b.ring = r[2:0];
    b.tag = t;
    pending_beats.push_back(b);
    if (op == swdd_pkg::OP_CLEAR) gen_newest[r] = '0;
    else if (!(t <= gen_newest[r] && (gen_newest[r] - t) < WIN)) gen_newest[r] = t;
  endtask

  // Random beat, mostly near the ring's newest tag so the window logic gets exercised.
  task automatic queue_random_beat();
    int unsigned r;
    int unsigned pick;
    swdd_pkg::tag_t n;
    r = $urandom_range(RINGS - 1);
    pick = $urandom_range(99);
    n = gen_newest[r];
    if (pick < 3)       queue_beat(swdd_pkg::OP_CLEAR, r, {$urandom, $urandom});
    else if (pick < 8)  queue_beat(swdd_pkg::OP_CHECK, r, {$urandom, $urandom});
    else if (pick < 12) queue_beat(swdd_pkg::OP_CHECK, r, n + $urandom_range(WIN, WIN + 4000));
    else if (pick < 14) queue_beat(swdd_pkg::OP_CHECK, r, n - $urandom_range(WIN, WIN + 4000));
    else if (pick < 24) queue_beat(swdd_pkg::OP_CHECK, r, n + $urandom_range(64, WIN - 1));
    else if (pick < 36) queue_beat(swdd_pkg::OP_CHECK, r, n - $urandom_range(0, WIN - 1));
    else                queue_beat(swdd_pkg::OP_CHECK, r, n + $urandom_range(80) - 40);
  endtask

  // Sample acceptance on the rising edge and fold the beat into the mirror.
  always @(posedge clk) begin
    logic d;
    beat_t b;
    in_took = rst_n && in_valid && !in_stall;
    if (in_took) begin
      b.op = swdd_pkg::op_t'(in_operation);
      b.ring = in_ring_id;
      b.tag = in_tag;
      window_update(b, d);
      dup_expected.push_back(d);
    end
  end

  // Driver: new beat on the falling edge once the last one was taken.
  always @(negedge clk) begin
    beat_t b;
    if (rst_n && (!in_valid || in_took)) begin
      if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        b = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_operation <= b.op;
        in_ring_id <= b.ring;
        in_tag <= b.tag;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor: every result beat is checked against the oldest expectation.
  always @(posedge clk) begin
    logic want;
    if (rst_n && out_valid && !out_stall) begin
      if (dup_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat, duplicate=%b", out_duplicate);
      end else begin
        want = dup_expected.pop_front();
        if (out_duplicate !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("duplicate mismatch: expected %b, got %b", want, out_duplicate);
        end
      end
    end
  end

  initial begin
    swdd_pkg::tag_t top;
    top = '1;
    for (int r = 0; r < RINGS; r++) begin
      ring_wipe(r);
      gen_newest[r] = '0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fresh ring, edges of the window, wrap of the slot, restarts, clear.
    queue_beat(swdd_pkg::OP_CHECK, 0, 64'd0);          // fresh ring, tag 0 unique
    queue_beat(swdd_pkg::OP_CHECK, 0, 64'd0);          // now a duplicate
    queue_beat(swdd_pkg::OP_CHECK, 0, 64'd1);
    queue_beat(swdd_pkg::OP_CHECK, 0, 64'd32768);      // largest advance, slot wraps
    queue_beat(swdd_pkg::OP_CHECK, 0, 64'd1);          // oldest slot still in window
    queue_beat(swdd_pkg::OP_CHECK, 0, 64'd1);
    queue_beat(swdd_pkg::OP_CHECK, 0, 64'd0);          // one past the window behind: restart
    queue_beat(swdd_pkg::OP_CHECK, 0, 64'd32768);      // one past the window ahead: restart
    queue_beat(swdd_pkg::OP_CHECK, 0, 64'd32768);
    queue_beat(swdd_pkg::OP_CHECK, 7, top);            // largest tag
    queue_beat(swdd_pkg::OP_CHECK, 7, top - 1);
    queue_beat(swdd_pkg::OP_CHECK, 7, top - 1);
    queue_beat(swdd_pkg::OP_CHECK, 7, top - 32767);
    queue_beat(swdd_pkg::OP_CHECK, 7, top);
    queue_beat(swdd_pkg::OP_CLEAR, 7, top);            // clear, then tag 0 is unique again
    queue_beat(swdd_pkg::OP_CHECK, 7, 64'd0);
    queue_beat(swdd_pkg::OP_CHECK, 7, 64'd0);
    queue_beat(swdd_pkg::OP_CHECK, 3, 64'h5555_5555_5555_5555);
    queue_beat(swdd_pkg::OP_CHECK, 3, 64'hAAAA_AAAA_AAAA_AAAA);
    queue_beat(swdd_pkg::OP_CLEAR, 5, 64'd0);
    queue_beat(swdd_pkg::OP_CHECK, 5, 64'd100);
    queue_beat(swdd_pkg::OP_CHECK, 5, 64'd40);

    // Hold off until everything queued so far has come back.
    wait (pending_beats.size() == 0 && !in_valid && dup_expected.size() == 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 67; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 67; end
        default: begin send_idle_pct = 31; stall_pct = 31; end
      endcase
      for (int i = 0; i < 332; i++) queue_random_beat();
      wait (pending_beats.size() == 0);
    end

    wait (!in_valid && dup_expected.size() == 0);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && dup_expected.size() == 0)
      $display("[sliding_window_duplicate_detector] OK");
    else
      $display("[sliding_window_duplicate_detector] ERROR");
    $finish;
  end

  initial begin
    #40000000;
    $display("[sliding_window_duplicate_detector] ERROR");
    $finish;
  end
endmodule
